FILE: sv/s256_pkg.sv
package s256_pkg;

    typedef logic [31:0] word_t;

    // request opcodes
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // commands from the sequencer to the round unit
    typedef struct packed {
        logic start;
        logic restart;
    } s256_ctl_t;

    // round unit status back to the sequencer
    typedef struct packed {
        logic step;
        logic done;
    } s256_stat_t;

    // initial hash values
    localparam word_t H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // round constants
    localparam word_t K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // big sigma 0: rotr 2, 13, 22
    function automatic word_t bsig0(word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    // big sigma 1: rotr 6, 11, 25
    function automatic word_t bsig1(word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    // small sigma 0: rotr 7, 18, shr 3
    function automatic word_t ssig0(word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    // small sigma 1: rotr 17, 19, shr 10
    function automatic word_t ssig1(word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

FILE: sv/s256_sched.sv
module s256_sched
    import s256_pkg::*;
(
    input  logic        aclk,
    input  logic        byte_en,
    input  logic [7:0]  byte_in,
    input  logic        step,
    output word_t       w_t
);

    // 16-word window: block buffer while bytes arrive, message schedule during rounds
    word_t win_reg [16];
    word_t w_new;

    // next schedule word
    assign w_new = ssig1(win_reg[14]) + win_reg[9] + ssig0(win_reg[1]) + win_reg[0];
    assign w_t   = win_reg[0];

    // byte shift on load, word shift per round
    always_ff @(posedge aclk) begin
        if (byte_en) begin
            for (int i = 0; i < 15; i++) begin
                win_reg[i] <= {win_reg[i][23:0], win_reg[i+1][31:24]};
            end
            win_reg[15] <= {win_reg[15][23:0], byte_in};
        end else if (step) begin
            for (int i = 0; i < 15; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= w_new;
        end
    end

endmodule

FILE: sv/s256_round.sv
module s256_round
    import s256_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  s256_ctl_t   ctl,
    input  word_t       w_t,
    output s256_stat_t  stat,
    output word_t       hash_o [8]
);

    word_t      hash_reg [8];
    word_t      v_reg [8];
    logic [5:0] rnd_reg;
    logic       run_reg;
    logic       add_reg;

    word_t t1;
    word_t t2;
    word_t ch;
    word_t maj;

    // one compression round
    assign ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1  = v_reg[7] + bsig1(v_reg[4]) + ch + K_TABLE[rnd_reg] + w_t;
    assign t2  = bsig0(v_reg[0]) + maj;

    assign stat.step = run_reg;
    assign stat.done = add_reg;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            hash_o[i] = hash_reg[i];
        end
    end

    // round counter and hash update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            add_reg  <= 1'b0;
            rnd_reg  <= '0;
            hash_reg <= H_INIT;
        end else begin
            if (ctl.start) begin
                run_reg <= 1'b1;
                rnd_reg <= '0;
            end else if (run_reg) begin
                rnd_reg <= rnd_reg + 6'd1;
                if (&rnd_reg) begin
                    run_reg <= 1'b0;
                    add_reg <= 1'b1;
                end
            end
            if (add_reg) begin
                add_reg <= 1'b0;
                for (int i = 0; i < 8; i++) begin
                    hash_reg[i] <= hash_reg[i] + v_reg[i];
                end
            end else if (ctl.restart) begin
                hash_reg <= H_INIT;
            end
        end
    end

    // working variables a..h
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            v_reg <= hash_reg;
        end else if (run_reg) begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

endmodule

FILE: sv/sha256_stream_hasher.sv
// SHA-256 hasher over a byte stream.
// Input channel (s_valid/s_ready): one request per message byte with
// s_opcode = 0, or s_opcode = 1 to close the message. A finish request
// pads the message (0x80, zeros, 64-bit bit length) and then sends eight
// requests on the output channel (m_valid/m_ready): h0..h7 in order, with
// m_word_index on every word and m_last_word set on h7.
// The 64th byte of a block starts the shared round unit; s_ready then
// stays low through the 64 rounds and the hash add. A finish request is
// followed by the padding bytes (64 - pos, or 128 - pos when the length
// spills into a second block), a compression per padded block, and then
// the eight words.
// The round unit is the single shared resource and sets the rate.
// s_ready is low while padding, compressing or emitting the digest.
// A stalled receiver holds the word in the output register; the digest
// sequencer waits. The last word leaves the register while new bytes
// of the next message can already be accepted.
// Reset (aresetn low, synchronous) loads the initial hash values and
// clears the byte count; the block buffer needs no clearing.
module sha256_stream_hasher
    import s256_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PAD  = 2'd1;
    localparam logic [1:0] ST_COMP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]  state_reg,  state_next;
    logic [5:0]  pos_reg,    pos_next;
    logic [60:0] count_reg,  count_next;
    logic        marker_reg, marker_next;
    logic        spill_reg,  spill_next;
    logic        fin_reg,    fin_next;
    logic [2:0]  idx_reg,    idx_next;
    logic        mvalid_reg, mvalid_next;
    logic [31:0] mword_reg,  mword_next;
    logic [2:0]  midx_reg,   midx_next;
    logic        mlast_reg,  mlast_next;

    logic        wr_en;
    logic [7:0]  wr_byte;
    s256_ctl_t   ctl;
    s256_stat_t  stat;
    word_t       w_t;
    word_t       hash_words [8];

    logic        accept;
    logic        out_load;
    logic [63:0] len_bits;
    logic [2:0]  len_sel;
    logic [7:0]  len_byte;

    s256_sched u_sched (
        .aclk    (aclk),
        .byte_en (wr_en),
        .byte_in (wr_byte),
        .step    (stat.step),
        .w_t     (w_t)
    );

    s256_round u_round (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .w_t     (w_t),
        .stat    (stat),
        .hash_o  (hash_words)
    );

    assign s_ready       = (state_reg == ST_IDLE);
    assign accept        = s_valid && s_ready;
    assign m_valid       = mvalid_reg;
    assign m_digest_word = mword_reg;
    assign m_word_index  = midx_reg;
    assign m_last_word   = mlast_reg;

    // big-endian length byte for the current pad position
    assign len_bits = {count_reg, 3'b000};
    assign len_sel  = 3'd7 - pos_reg[2:0];
    assign len_byte = len_bits[{len_sel, 3'b000} +: 8];

    assign out_load = (state_reg == ST_EMIT) && (!mvalid_reg || m_ready);

    // sequencer
    always_comb begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        marker_next = marker_reg;
        spill_next  = spill_reg;
        fin_next    = fin_reg;
        idx_next    = idx_reg;
        wr_en       = 1'b0;
        wr_byte     = s_data_byte;
        ctl         = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_opcode == OP_APPEND) begin
                        wr_en      = 1'b1;
                        pos_next   = pos_reg + 6'd1;
                        count_next = count_reg + 61'd1;
                        fin_next   = 1'b0;
                        if (&pos_reg) begin
                            ctl.start  = 1'b1;
                            state_next = ST_COMP;
                        end
                    end else begin
                        fin_next    = 1'b1;
                        marker_next = 1'b0;
                        state_next  = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                wr_en       = 1'b1;
                marker_next = 1'b1;
                pos_next    = pos_reg + 6'd1;
                if (!marker_reg) begin
                    wr_byte    = 8'h80;
                    spill_next = (pos_reg[5:3] == 3'b111);
                end else if (pos_reg[5:3] == 3'b111 && !spill_reg) begin
                    wr_byte = len_byte;
                end else begin
                    wr_byte = 8'h00;
                end
                if (&pos_reg) begin
                    ctl.start  = 1'b1;
                    state_next = ST_COMP;
                end
            end
            ST_COMP: begin
                if (stat.done) begin
                    if (!fin_reg) begin
                        state_next = ST_IDLE;
                    end else if (spill_reg) begin
                        spill_next = 1'b0;
                        state_next = ST_PAD;
                    end else begin
                        idx_next   = '0;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    idx_next = idx_reg + 3'd1;
                    if (&idx_reg) begin
                        ctl.restart = 1'b1;
                        count_next  = '0;
                        pos_next    = '0;
                        fin_next    = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        mvalid_next = mvalid_reg;
        mword_next  = mword_reg;
        midx_next   = midx_reg;
        mlast_next  = mlast_reg;
        if (out_load) begin
            mvalid_next = 1'b1;
            mword_next  = hash_words[idx_reg];
            midx_next   = idx_reg;
            mlast_next  = &idx_reg;
        end else if (m_ready) begin
            mvalid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            pos_reg    <= '0;
            count_reg  <= '0;
            marker_reg <= 1'b0;
            spill_reg  <= 1'b0;
            fin_reg    <= 1'b0;
            idx_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            count_reg  <= count_next;
            marker_reg <= marker_next;
            spill_reg  <= spill_next;
            fin_reg    <= fin_next;
            idx_reg    <= idx_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        mword_reg <= mword_next;
        midx_reg  <= midx_next;
        mlast_reg <= mlast_next;
    end

    // a compression start always enters the compress state
    a_start_comp: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.start |=> state_reg == ST_COMP)
        else $error("round unit started outside compress entry");

    // the round unit finishes only while the sequencer waits for it
    a_done_comp: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done |-> state_reg == ST_COMP)
        else $error("round unit done outside compress state");

    // the last flag rides only on h7
    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_word) |-> m_word_index == 3'd7)
        else $error("last word flag on wrong word");

    // restart clears the byte count
    a_restart_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.restart |=> (count_reg == '0 && state_reg == ST_IDLE))
        else $error("restart left stale count");

endmodule
